// ===== src/uwt_pkg.sv =====
`default_nettype none

package uwt_pkg;

  // Table capacity and field widths.
  localparam int unsigned MaxMembers = 32;
  localparam int unsigned IdxW       = $clog2(MaxMembers);
  localparam int unsigned CntW       = 6;
  localparam int unsigned UidW       = 32;
  localparam int unsigned ActW       = 3;

  typedef enum logic [ActW-1:0] {
    ACT_LOOKUP       = 3'd0,
    ACT_ADD          = 3'd1,
    ACT_DELETE       = 3'd2,
    ACT_SET_MASTER   = 3'd3,
    ACT_CLEAR_MASTER = 3'd4,
    ACT_DELETE_ALL   = 3'd5
  } action_e;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SCAN    = 6'b000010,
    ST_EXEC    = 6'b000100,
    ST_MOVE_RD = 6'b001000,
    ST_MOVE_WR = 6'b010000,
    ST_DONE    = 6'b100000
  } state_e;

  typedef struct packed {
    logic accept;
    logic scan;
    logic exec;
    logic move_rd;
    logic move_wr;
    logic out_load;
  } uwt_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic del_hit;
    logic out_free;
  } uwt_status_t;

endpackage

`default_nettype wire

// ===== src/uwt_ctrl.sv =====
`default_nettype none

module uwt_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire uwt_pkg::uwt_status_t status_i,
  output uwt_pkg::uwt_cmd_t        cmd_o
);
  import uwt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) begin
          // A delete that hit needs the last entry read before the move.
          state_d = status_i.del_hit ? ST_MOVE_RD : ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_DONE;
      end
      ST_MOVE_RD: begin
        cmd_o.move_rd = 1'b1;
        state_d       = ST_MOVE_WR;
      end
      ST_MOVE_WR: begin
        cmd_o.move_wr = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

`ifndef SYNTHESIS
  a_accept_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_SCAN))
    else $error("accepted item did not start a scan");
  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> status_i.out_free)
    else $error("result loaded while output register busy");
  a_move_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MOVE_RD) |=> (state_q == ST_MOVE_WR))
    else $error("move read not followed by move write");
`endif

endmodule

`default_nettype wire

// ===== src/uwt_dpath.sv =====
`default_nettype none

module uwt_dpath (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire uwt_pkg::uwt_cmd_t         cmd_i,
  output uwt_pkg::uwt_status_t           status_o,
  input  wire logic [uwt_pkg::ActW-1:0]  action_i,
  input  wire logic [uwt_pkg::UidW-1:0]  uid_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           ok_o,
  output logic [uwt_pkg::CntW-1:0]       found_index_o,
  output logic                           is_master_o,
  output logic [uwt_pkg::CntW-1:0]       member_count_o,
  output logic                           master_present_o
);
  import uwt_pkg::*;

  logic [UidW-1:0] mem_q [MaxMembers];

  action_e         action_q;
  logic [UidW-1:0] uid_q;
  logic [CntW-1:0] count_q, count_d;
  logic [UidW-1:0] master_q, master_d;
  logic            flag_q, flag_d;
  logic            hit_q;
  logic            ok_q, ok_d;
  logic [CntW-1:0] found_q, found_d;
  logic [CntW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0] cmp_idx_q;
  logic            cmp_valid_q, cmp_valid_d;
  logic [UidW-1:0] rdata_q;

  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [UidW-1:0] wr_data;
  logic            issue;
  logic            out_free;
  logic [CntW-1:0] last_idx;
  logic [CntW-1:0] slot_idx;

  assign last_idx = count_q - CntW'(1);
  assign slot_idx = found_q - CntW'(1);

  // At most one read per scan cycle; its compare is in the next cycle.
  assign issue   = cmd_i.scan && (found_q == '0) && (ptr_q < count_q);
  assign rd_en   = issue || cmd_i.move_rd;
  assign rd_addr = cmd_i.move_rd ? last_idx[IdxW-1:0] : ptr_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_e'(action_i);
      uid_q    <= uid_i;
      hit_q    <= flag_q && (master_q == uid_i);
    end
    if (issue) begin
      cmp_idx_q <= ptr_q;
    end
  end

  always_comb begin
    ptr_d       = ptr_q;
    found_d     = found_q;
    cmp_valid_d = issue;
    count_d     = count_q;
    master_d    = master_q;
    flag_d      = flag_q;
    ok_d        = ok_q;
    wr_en       = 1'b0;
    wr_addr     = count_q[IdxW-1:0];
    wr_data     = uid_q;

    if (cmd_i.accept) begin
      ptr_d   = '0;
      found_d = '0;
    end
    if (issue) begin
      ptr_d = ptr_q + CntW'(1);
    end
    if (cmp_valid_q && (found_q == '0) && (rdata_q == uid_q)) begin
      found_d = cmp_idx_q + CntW'(1);
    end

    if (cmd_i.exec) begin
      ok_d = 1'b0;
      case (action_q)
        ACT_LOOKUP: begin
          ok_d = (found_q != '0);
        end
        ACT_ADD: begin
          if ((found_q == '0) && (count_q < CntW'(MaxMembers))) begin
            wr_en   = 1'b1;
            count_d = count_q + CntW'(1);
            ok_d    = 1'b1;
          end
        end
        ACT_SET_MASTER: begin
          master_d = uid_q;
          flag_d   = 1'b1;
          ok_d     = 1'b1;
        end
        ACT_CLEAR_MASTER: begin
          if (flag_q) begin
            flag_d   = 1'b0;
            master_d = '1;
            ok_d     = 1'b1;
          end
        end
        ACT_DELETE_ALL: begin
          if (count_q != '0) begin
            count_d = '0;
            ok_d    = 1'b1;
          end
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end

    // The last entry fills the freed slot.
    if (cmd_i.move_wr) begin
      wr_en   = 1'b1;
      wr_addr = slot_idx[IdxW-1:0];
      wr_data = rdata_q;
      count_d = last_idx;
      ok_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      master_q    <= '1;
      flag_q      <= 1'b0;
      ok_q        <= 1'b0;
      found_q     <= '0;
      ptr_q       <= '0;
      cmp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      master_q    <= master_d;
      flag_q      <= flag_d;
      ok_q        <= ok_d;
      found_q     <= found_d;
      ptr_q       <= ptr_d;
      cmp_valid_q <= cmp_valid_d;
    end
  end

  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ok_o             <= ok_q;
      found_index_o    <= found_q;
      is_master_o      <= hit_q;
      member_count_o   <= count_q;
      master_present_o <= flag_q;
    end
  end

  assign status_o.scan_done = !cmp_valid_q && ((found_q != '0) || (ptr_q >= count_q));
  assign status_o.del_hit   = (action_q == ACT_DELETE) && (found_q != '0);
  assign status_o.out_free  = out_free;

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxMembers))
    else $error("member count exceeds capacity");
  a_master_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !flag_q |-> (master_q == '1))
    else $error("master value kept without master flag");
  a_found_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.del_hit && cmd_i.scan |-> (found_q <= count_q))
    else $error("matched slot beyond member count");
`endif

endmodule

`default_nettype wire

// ===== src/uid_whitelist_table.sv =====
// The member scan reads one stored UID per cycle from the table memory, stopping
// at the first match or at the end of the list. Items are handled one at a time.
// A new item is taken while the previous result still waits in the output register.
// Reset (asynchronous, active low) empties the list, clears the master flag and
// sets the master value to all ones; the table memory itself is not cleared.
`default_nettype none

module uid_whitelist_table (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [uwt_pkg::ActW-1:0]  action_i,
  input  wire logic [uwt_pkg::UidW-1:0]  uid_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           ok_o,
  output logic [uwt_pkg::CntW-1:0]       found_index_o,
  output logic                           is_master_o,
  output logic [uwt_pkg::CntW-1:0]       member_count_o,
  output logic                           master_present_o
);
  import uwt_pkg::*;

  uwt_cmd_t    cmd;
  uwt_status_t status;

  uwt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  uwt_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .action_i         (action_i),
    .uid_i            (uid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ok_o             (ok_o),
    .found_index_o    (found_index_o),
    .is_master_o      (is_master_o),
    .member_count_o   (member_count_o),
    .master_present_o (master_present_o)
  );

endmodule

`default_nettype wire

// ===== bench/uid_table_monitor.sv =====
`default_nettype none

module uid_table_monitor
  import uwt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire logic [ActW-1:0]  action_i,
  input  wire logic [UidW-1:0]  uid_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire logic             ok_i,
  input  wire logic [CntW-1:0]  found_index_i,
  input  wire logic             is_master_i,
  input  wire logic [CntW-1:0]  member_count_i,
  input  wire logic             master_present_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ActW-1:0] act;
    logic [UidW-1:0] uid;
    logic            ok;
    logic [CntW-1:0] found_index;
    logic            is_master;
    logic [CntW-1:0] member_count;
    logic            master_present;
  } table_reply_t;

  // Our own copy of the table contents.
  logic [UidW-1:0] roster [MaxMembers];
  int unsigned     roster_count = 0;
  logic [UidW-1:0] master_uid = '1;
  logic            master_set = 1'b0;

  table_reply_t expected_replies [$];
  int unsigned  mismatches = 0;
  int unsigned  replies_seen = 0;
  int unsigned  waiting = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = waiting;

  function automatic table_reply_t apply_card_action(input logic [ActW-1:0] act,
                                                     input logic [UidW-1:0] uid);
    table_reply_t r;
    int unsigned  slot;
    int unsigned  k;
    slot = 0;
    for (k = 0; k < roster_count; k++) begin
      if (slot == 0 && roster[k] == uid) begin
        slot = k + 1;
      end
    end
    r             = '0;
    r.act         = act;
    r.uid         = uid;
    r.found_index = CntW'(slot);
    r.is_master   = master_set && (master_uid == uid);
    case (act)
      ACT_LOOKUP: begin
        r.ok = (slot != 0);
      end
      ACT_ADD: begin
        if (slot == 0 && roster_count < MaxMembers) begin
          roster[roster_count] = uid;
          roster_count++;
          r.ok = 1'b1;
        end
      end
      ACT_DELETE: begin
        // The last entry fills the hole so the list stays compact.
        if (slot != 0) begin
          roster[slot-1] = roster[roster_count-1];
          roster_count--;
          r.ok = 1'b1;
        end
      end
      ACT_SET_MASTER: begin
        master_uid = uid;
        master_set = 1'b1;
        r.ok       = 1'b1;
      end
      ACT_CLEAR_MASTER: begin
        if (master_set) begin
          master_set = 1'b0;
          master_uid = '1;
          r.ok       = 1'b1;
        end
      end
      ACT_DELETE_ALL: begin
        if (roster_count != 0) begin
          roster_count = 0;
          r.ok         = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.member_count   = CntW'(roster_count);
    r.master_present = master_set;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: uid table mismatch on result %0d: %s", $time, replies_seen, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    table_reply_t want;
    if (!rst_ni) begin
      roster_count = 0;
      master_uid   = '1;
      master_set   = 1'b0;
      expected_replies.delete();
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          report_mismatch("result arrived with no item outstanding");
        end else begin
          want = expected_replies.pop_front();
          if (ok_i !== want.ok) begin
            report_mismatch($sformatf("action %0d uid %h: ok %b, want %b",
                                      want.act, want.uid, ok_i, want.ok));
          end
          if (found_index_i !== want.found_index) begin
            report_mismatch($sformatf("action %0d uid %h: found_index %0d, want %0d",
                                      want.act, want.uid, found_index_i, want.found_index));
          end
          if (is_master_i !== want.is_master) begin
            report_mismatch($sformatf("action %0d uid %h: is_master %b, want %b",
                                      want.act, want.uid, is_master_i, want.is_master));
          end
          if (member_count_i !== want.member_count) begin
            report_mismatch($sformatf("action %0d uid %h: member_count %0d, want %0d",
                                      want.act, want.uid, member_count_i, want.member_count));
          end
          if (master_present_i !== want.master_present) begin
            report_mismatch($sformatf("action %0d uid %h: master_present %b, want %b",
                                      want.act, want.uid, master_present_i,
                                      want.master_present));
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        expected_replies.push_back(apply_card_action(action_i, uid_i));
      end
    end
    waiting = expected_replies.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb_uid_whitelist_table.sv =====
`default_nettype none

module tb_uid_whitelist_table;

  timeunit 1ns;
  timeprecision 1ps;

  import uwt_pkg::*;

  localparam logic [ActW-1:0] ActUnused6 = 3'd6;
  localparam logic [ActW-1:0] ActUnused7 = 3'd7;
  localparam int unsigned     PoolSize   = 40;
  localparam int unsigned     PhaseItems = 216;
  localparam int unsigned     HoldCycles = 300;

  typedef enum int unsigned {
    MIX_FILL,
    MIX_CHURN,
    MIX_DRAIN
  } traffic_mix_e;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_stall_o;
  logic [ActW-1:0] action_i;
  logic [UidW-1:0] uid_i;
  logic            out_valid_o;
  logic            out_stall_i;
  logic            ok_o;
  logic [CntW-1:0] found_index_o;
  logic            is_master_o;
  logic [CntW-1:0] member_count_o;
  logic            master_present_o;

  int unsigned fail_count;
  int unsigned pending;

  logic [UidW-1:0] uid_pool [PoolSize];
  bit              tx_idle_on = 1'b0;
  bit              rx_idle_on = 1'b0;
  int unsigned     holds_asked = 0;

  uid_whitelist_table i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .uid_i            (uid_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ok_o             (ok_o),
    .found_index_o    (found_index_o),
    .is_master_o      (is_master_o),
    .member_count_o   (member_count_o),
    .master_present_o (master_present_o)
  );

  uid_table_monitor i_monitor (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .action_i         (action_i),
    .uid_i            (uid_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ok_i             (ok_o),
    .found_index_i    (found_index_o),
    .is_master_i      (is_master_o),
    .member_count_i   (member_count_o),
    .master_present_i (master_present_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("tb_uid_whitelist_table: FAIL");
    $finish;
  end

  // Result side: random stalls when enabled, plus a long hold-off whenever one is asked for.
  initial begin : result_side
    int unsigned holds_done;
    int unsigned hold_left;
    holds_done = 0;
    hold_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= rx_idle_on && ($urandom_range(99) < 29);
      end
    end
  end

  // Valid stays high from one item to the next unless a gap is taken.
  task automatic present_card(input logic [ActW-1:0] act, input logic [UidW-1:0] uid);
    while (tx_idle_on && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    uid_i      <= uid;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  // Sampled on the falling edge so the monitor has taken the last accept into account.
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [ActW-1:0] choose_action(input traffic_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (roll < 60)      return ACT_ADD;
        else if (roll < 80) return ACT_LOOKUP;
        else if (roll < 88) return ACT_DELETE;
        else if (roll < 93) return ACT_SET_MASTER;
        else if (roll < 97) return ACT_CLEAR_MASTER;
      end
      MIX_CHURN: begin
        if (roll < 30)      return ACT_ADD;
        else if (roll < 58) return ACT_DELETE;
        else if (roll < 80) return ACT_LOOKUP;
        else if (roll < 87) return ACT_SET_MASTER;
        else if (roll < 93) return ACT_CLEAR_MASTER;
        else if (roll < 95) return ACT_DELETE_ALL;
      end
      default: begin
        if (roll < 45)      return ACT_DELETE;
        else if (roll < 70) return ACT_LOOKUP;
        else if (roll < 85) return ACT_ADD;
        else if (roll < 89) return ACT_SET_MASTER;
        else if (roll < 93) return ACT_CLEAR_MASTER;
        else if (roll < 95) return ACT_DELETE_ALL;
      end
    endcase
    return $urandom_range(1) ? ActUnused6 : ActUnused7;
  endfunction

  // A small pool makes repeats, hits and a full list common; some UIDs are fully random.
  function automatic logic [UidW-1:0] choose_uid();
    if ($urandom_range(99) < 15) begin
      return $urandom;
    end
    return uid_pool[$urandom_range(PoolSize-1)];
  endfunction

  task automatic run_phase(input traffic_mix_e mix, input bit tx_gaps, input bit rx_gaps,
                           input bit long_hold);
    tx_idle_on = tx_gaps;
    rx_idle_on = rx_gaps;
    if (long_hold) begin
      holds_asked++;
    end
    repeat (PhaseItems) begin
      present_card(choose_action(mix), choose_uid());
    end
    wait_for_drain();
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= ACT_LOOKUP;
    uid_i      <= '0;
    uid_pool[0] = '0;
    uid_pool[1] = '1;
    uid_pool[2] = 32'h8000_0001;
    for (int unsigned k = 3; k < PoolSize; k++) begin
      uid_pool[k] = $urandom;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: the all-ones master value must not count without the flag.
    present_card(ACT_LOOKUP, '1);
    present_card(ACT_CLEAR_MASTER, '0);
    present_card(ACT_DELETE_ALL, '0);
    present_card(ACT_DELETE, 32'h0000_0005);
    present_card(ACT_ADD, '0);
    present_card(ACT_ADD, '1);
    present_card(ACT_ADD, '0);
    present_card(ACT_ADD, 32'h8000_0001);
    present_card(ACT_LOOKUP, '1);
    present_card(ACT_SET_MASTER, '1);
    present_card(ACT_LOOKUP, '1);
    present_card(ACT_SET_MASTER, 32'h1234_5678);
    present_card(ACT_LOOKUP, '1);
    present_card(ACT_CLEAR_MASTER, '0);
    present_card(ACT_CLEAR_MASTER, '0);
    // Deleting the first entry pulls the last one into slot 1.
    present_card(ACT_DELETE, '0);
    present_card(ACT_LOOKUP, 32'h8000_0001);
    present_card(ACT_DELETE, 32'h8000_0001);
    present_card(ActUnused6, '1);
    present_card(ActUnused7, '0);
    present_card(ACT_DELETE_ALL, '1);
    present_card(ACT_LOOKUP, '1);
    wait_for_drain();

    run_phase(MIX_FILL,  1'b0, 1'b0, 1'b0);
    run_phase(MIX_CHURN, 1'b1, 1'b1, 1'b1);
    run_phase(MIX_DRAIN, 1'b1, 1'b0, 1'b0);
    run_phase(MIX_FILL,  1'b0, 1'b1, 1'b0);
    run_phase(MIX_CHURN, 1'b1, 1'b1, 1'b0);

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_uid_whitelist_table: PASS");
    end else begin
      $display("tb_uid_whitelist_table: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
